FILE: rtl/bqlp_pkg.sv
// ----------------------------------------------------------------------------
// bqlp_pkg
// Shared types and constants for the biquad low-pass filter: history format,
// saturation limits and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package bqlp_pkg;

  // Histories and output are signed Q16.8.
  localparam int HIST_BITS = 24;
  localparam int HIST_FRAC = 8;

  // Register widths.
  localparam int GAIN_BITS = 16;
  localparam int FB_BITS   = 18;
  localparam int CFG_BITS  = 18;
  localparam int CFG_IDX_BITS = 2;

  typedef logic signed [HIST_BITS-1:0] hist_t;
  typedef logic        [GAIN_BITS-1:0] gain_t;
  typedef logic signed [FB_BITS-1:0]   fb_t;
  typedef logic signed [HIST_BITS+FB_BITS-1:0] fb_prod_t;

  localparam hist_t HIST_MAX = 24'sh7FFFFF;
  localparam hist_t HIST_MIN = 24'sh800000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_INPUT_GAIN   = 2'd0,
    CFG_FEEDBACK_ONE = 2'd1,
    CFG_FEEDBACK_TWO = 2'd2,
    CFG_BURN_IN      = 2'd3
  } cfg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/biquad_lowpass_filter.sv
// ----------------------------------------------------------------------------
// biquad_lowpass_filter
// Second-order IIR low-pass (numerator 1,2,1, programmable feedback b1, b2)
// with an unsigned input gain and saturating Q16.8 output.
// ----------------------------------------------------------------------------
// The block takes one signed sample per input transaction and returns one
// filtered Q16.8 value per sample, in order. Each sample is scaled by
// input_gain (Q0.16), rounded to 8 fraction bits and saturated to 24 bits,
// then filtered by y = x + 2*x1 + x2 - b1*y1 - b2*y2, where the sum is formed
// exactly and rounded (to nearest, ties up) and saturated to 24 bits. The
// first sample after reset only primes the histories: with burn_in set it
// fills them with the scaled sample and returns it, otherwise it returns zero.
// Throughput is one sample per clock cycle while results are taken. An item
// passes three registers in order (input register, scaled-sample register,
// result register), and out_tvalid rises once it reaches the result register.
// The cycle time is set by the feedback path, where the two 18x24
// coefficient products of the previous results are summed, rounded and
// saturated before they are stored back into the history. Each stage holds
// its item while the stage after it is full, so the input keeps accepting
// transactions while a result waits on out_tready, until all three stages
// are occupied. Configuration must be written only while the block is idle.
`default_nettype none

module biquad_lowpass_filter #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,

  input  wire logic                                  cfg_wen,
  input  wire logic [bqlp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [bqlp_pkg::CFG_BITS-1:0]         cfg_wdata,

  input  wire logic                                  in_tvalid,
  output      logic                                  in_tready,
  // Fields from bit 0 up: sample (SAMPLE_BITS, signed), zero padding.
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,

  output      logic                                  out_tvalid,
  input  wire logic                                  out_tready,
  // Fields from bit 0 up: filtered (24 bits, signed Q16.8).
  output      logic [bqlp_pkg::HIST_BITS-1:0]        out_tdata
);

  import bqlp_pkg::*;

  // Gain product is sample times a zero-extended gain; XW leaves room for the
  // rounding add and for the saturation limits.
  localparam int GPW = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int XW  = (GPW + 1 > HIST_BITS + 1) ? GPW + 1 : HIST_BITS + 1;
  localparam int XSH = COEF_FRAC_BITS - HIST_FRAC;

  // The numerator sum x + 2*x1 + x2 needs HIST_BITS+2 bits before scaling.
  localparam int NW  = HIST_BITS + 2 + COEF_FRAC_BITS;
  localparam int PW  = HIST_BITS + FB_BITS;
  localparam int AW  = ((NW > PW) ? NW : PW) + 3;

  localparam logic signed [XW-1:0] X_HALF = XW'(1) <<< (XSH - 1);
  localparam logic signed [XW-1:0] X_MAX  = XW'(HIST_MAX);
  localparam logic signed [XW-1:0] X_MIN  = XW'(HIST_MIN);
  localparam logic signed [AW-1:0] A_HALF = AW'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [AW-1:0] A_MAX  = AW'(HIST_MAX);
  localparam logic signed [AW-1:0] A_MIN  = AW'(HIST_MIN);

  // Configuration registers.
  gain_t gain_r;
  fb_t   fb_one_r;
  fb_t   fb_two_r;
  logic  burn_in_r;

  // Pipeline registers.
  logic                          s_v_r;
  logic signed [SAMPLE_BITS-1:0] s_r;
  logic                          x_v_r;
  hist_t                         x_r;
  logic                          out_v_r;
  hist_t                         out_data_r;

  // Filter state.
  logic  started_r;
  hist_t in_hist_one_r;
  hist_t in_hist_two_r;
  hist_t out_hist_one_r;
  hist_t out_hist_two_r;

  // Stage handshakes: a stage can take an item when it is empty or when its
  // content moves on in the same cycle.
  logic out_rdy;
  logic x_rdy;
  logic s_rdy;
  logic out_load;

  assign out_rdy  = !out_v_r || out_tready;
  assign x_rdy    = !x_v_r || out_rdy;
  assign s_rdy    = !s_v_r || x_rdy;
  assign out_load = x_v_r && out_rdy;

  assign in_tready  = s_rdy;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= '0;
      fb_one_r  <= '0;
      fb_two_r  <= '0;
      burn_in_r <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INPUT_GAIN:   gain_r    <= cfg_wdata[GAIN_BITS-1:0];
        CFG_FEEDBACK_ONE: fb_one_r  <= cfg_wdata[FB_BITS-1:0];
        CFG_FEEDBACK_TWO: fb_two_r  <= cfg_wdata[FB_BITS-1:0];
        CFG_BURN_IN:      burn_in_r <= cfg_wdata[0];
        default:          burn_in_r <= burn_in_r;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (s_rdy) begin
      s_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && s_rdy) begin
      s_r <= in_tdata[SAMPLE_BITS-1:0];
    end
  end

  // Scaled sample: round(sample * gain / 2^XSH), saturated to the history range.
  logic signed [GPW-1:0] gain_prod;
  logic signed [XW-1:0]  x_round;
  hist_t                 x_nxt;

  assign gain_prod = $signed(s_r) * $signed({1'b0, gain_r});
  assign x_round   = (XW'(gain_prod) + X_HALF) >>> XSH;

  always_comb begin
    if (x_round > X_MAX) begin
      x_nxt = HIST_MAX;
    end else if (x_round < X_MIN) begin
      x_nxt = HIST_MIN;
    end else begin
      x_nxt = x_round[HIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_v_r <= 1'b0;
    end else if (x_rdy) begin
      x_v_r <= s_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s_v_r && x_rdy) begin
      x_r <= x_nxt;
    end
  end

  // Filter stage: exact sum at HIST_FRAC+COEF_FRAC_BITS fraction bits.
  fb_prod_t             prod_one;
  fb_prod_t             prod_two;
  logic signed [AW-1:0] num_sum;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_round;
  hist_t                y_filt;
  hist_t                y_nxt;

  assign prod_one  = fb_one_r * out_hist_one_r;
  assign prod_two  = fb_two_r * out_hist_two_r;
  assign num_sum   = AW'(x_r) + (AW'(in_hist_one_r) <<< 1) + AW'(in_hist_two_r);
  assign acc       = (num_sum <<< COEF_FRAC_BITS) - AW'(prod_one) - AW'(prod_two);
  assign acc_round = (acc + A_HALF) >>> COEF_FRAC_BITS;

  always_comb begin
    if (acc_round > A_MAX) begin
      y_filt = HIST_MAX;
    end else if (acc_round < A_MIN) begin
      y_filt = HIST_MIN;
    end else begin
      y_filt = acc_round[HIST_BITS-1:0];
    end
  end

  // The first sample only primes the histories.
  always_comb begin
    if (!started_r) begin
      y_nxt = burn_in_r ? x_r : '0;
    end else begin
      y_nxt = y_filt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r        <= 1'b0;
      started_r      <= 1'b0;
      in_hist_one_r  <= '0;
      in_hist_two_r  <= '0;
      out_hist_one_r <= '0;
      out_hist_two_r <= '0;
    end else begin
      if (out_rdy) begin
        out_v_r <= x_v_r;
      end
      if (out_load) begin
        started_r      <= 1'b1;
        in_hist_one_r  <= x_r;
        out_hist_one_r <= y_nxt;
        if (!started_r) begin
          in_hist_two_r  <= y_nxt;
          out_hist_two_r <= y_nxt;
        end else begin
          in_hist_two_r  <= in_hist_one_r;
          out_hist_two_r <= out_hist_one_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= y_nxt;
    end
  end

  // Once a sample has passed, the filter stays out of its priming mode.
  a_started_stays: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("started flag dropped without reset");

  // A result only appears when the scaled-sample stage held an item.
  a_out_from_x: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(x_v_r))
    else $error("result became valid without a scaled sample");

  // The most recent output history is the value just presented.
  a_hist_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_hist_one_r == out_data_r) && out_v_r)
    else $error("output history differs from delivered result");

  // A stalled result is not overwritten by the stage behind it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |-> !out_load)
    else $error("result register loaded while stalled");

endmodule

`default_nettype wire
